[hw/rtl/hmac_pkg.sv]
// Package: shared constants and types for the HMAC-SHA1 unit
package hmac_pkg;

  localparam int unsigned KeyBytes = 64;
  localparam int unsigned KeyAw = 6;

  localparam logic [7:0] IpadByte = 8'h36;
  localparam logic [7:0] OpadByte = 8'h5c;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  localparam logic CmdKey = 1'b0;
  localparam logic CmdMsg = 1'b1;

  typedef logic [159:0] chain_t;

  // Handshake from the controller to the compression core
  typedef struct packed {
    logic   start;
    logic   use_iv;
    logic [511:0] block;
  } core_req_t;

  typedef struct packed {
    logic   done;
    chain_t hash;
  } core_rsp_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

[hw/rtl/hmac_core.sv]
// SHA-1 compression core: one round per cycle, schedule in a 16-entry window
module hmac_core (
  input  logic                clk,
  input  logic                rst,
  input  hmac_pkg::core_req_t req,
  output hmac_pkg::core_rsp_t rsp
);

  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [31:0] h [5];
  logic [6:0]  rnd;
  logic        busy;
  logic        done;

  logic [31:0] wt, f, k, t, wnew;

  // Select the round function and schedule word
  always_comb begin
    wnew = hmac_pkg::rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
    wt = (rnd < 7'd16) ? w[0] : wnew;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d); k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d; k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d; k = 32'hCA62C1D6;
    end
    t = hmac_pkg::rotl(a, 5) + f + e + k + wt;
  end

  // Advance rounds; fold into the chain at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (req.start && !busy) begin
      logic [31:0] s0, s1, s2, s3, s4;
      s0 = req.use_iv ? hmac_pkg::Iv0 : h[0];
      s1 = req.use_iv ? hmac_pkg::Iv1 : h[1];
      s2 = req.use_iv ? hmac_pkg::Iv2 : h[2];
      s3 = req.use_iv ? hmac_pkg::Iv3 : h[3];
      s4 = req.use_iv ? hmac_pkg::Iv4 : h[4];
      h[0] <= s0; h[1] <= s1; h[2] <= s2; h[3] <= s3; h[4] <= s4;
      a <= s0; b <= s1; c <= s2; d <= s3; e <= s4;
      for (int i = 0; i < 16; i++) w[i] <= req.block[511 - 32*i -: 32];
      busy <= 1'b1;
      rnd  <= '0;
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
      e <= d; d <= c; c <= hmac_pkg::rotl(b, 30); b <= a; a <= t;
      rnd <= rnd + 7'd1;
      if (rnd == 7'd79) begin
        busy <= 1'b0;
        h[0] <= h[0] + t;
        h[1] <= h[1] + a;
        h[2] <= h[2] + hmac_pkg::rotl(b, 30);
        h[3] <= h[3] + c;
        h[4] <= h[4] + d;
      end
    end
  end

  // Pulse done with the last round
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy && (rnd == 7'd79);
    end
  end

  assign rsp = {done, h[0], h[1], h[2], h[3], h[4]};

endmodule

[hw/rtl/hmac_sha1_authenticator_unit.sv]
// Top level: HMAC-SHA1 over a byte stream, key first then message
//
//  channel | dir | tdata                         | tuser   | tlast
//  s_axis  | in  | [7:0] data_byte               | command | last
//  m_axis  | out | [31:0] digest_word            | -       | word_last
//
// A byte is taken when valid and ready meet in the idle state; a full 64-byte
// block then holds input while the round core runs its 80 rounds (one per
// cycle). Key bytes live in a 64x8 synchronous memory read one byte per cycle
// when the pad blocks are built, after one step that primes the read. Message
// end adds up to four compressions. Reset is synchronous and clears the
// control state; the key memory is cleared logically through the key length.
// Output stalls hold the digest words; no new byte is taken until all five
// are delivered.
module hmac_sha1_authenticator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] command
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic        m_axis_tlast
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PAD   = 10'b0000000010,
    S_COMP  = 10'b0000000100,
    S_WAIT  = 10'b0000001000,
    S_FIN   = 10'b0000010000,
    S_KPREP = 10'b0000100000,
    S_IDIG  = 10'b0001000000,
    S_KDIG  = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_KCOPY = 10'b1000000000
  } state_t;

  // After-compression continuation
  typedef enum logic [3:0] {
    N_BYTE = 4'b0001, N_FIN = 4'b0010, N_IPAD = 4'b0100, N_OPAD = 4'b1000
  } nxt_t;

  state_t      state;
  nxt_t        nxt;
  logic [7:0]  key_mem [hmac_pkg::KeyBytes];
  logic [7:0]  key_rd;
  logic [6:0]  key_count;
  logic        key_hashed;
  logic        msg_phase;
  logic        outer;
  logic [511:0] blk;
  logic [63:0] total;
  logic        first_blk;
  logic [6:0]  pidx;
  logic [6:0]  pidx_m1;
  logic [7:0]  pad;
  logic [7:0]  parked;
  logic        fin_len;
  logic [2:0]  ocnt;
  logic [4:0]  ccnt;
  logic [159:0] inner;
  logic [159:0] dig;
  logic        core_start;
  logic        wait_seen;
  hmac_pkg::core_req_t req;
  hmac_pkg::core_rsp_t rsp;

  logic [5:0]  pos;
  logic        accept;
  logic        we;
  logic [5:0]  waddr;
  logic [7:0]  wdata;
  logic [5:0]  raddr;

  assign pos = total[5:0];
  assign pidx_m1 = pidx - 7'd1;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  hmac_core u_core (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // Start the core in the first cycle of each wait
  assign core_start = (state == S_WAIT) && !wait_seen;
  assign req = {core_start, first_blk, blk};

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_seen <= 1'b0;
    end else begin
      wait_seen <= (state == S_WAIT);
    end
  end

  // Key memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (we) key_mem[waddr] <= wdata;
    key_rd <= key_mem[raddr];
  end

  always_comb begin
    we = 1'b0; waddr = key_count[5:0]; wdata = s_axis_tdata;
    raddr = pidx[5:0];
    if (accept && !msg_phase && s_axis_tuser == hmac_pkg::CmdKey && key_count < 7'd64) begin
      we = 1'b1;
    end else if (state == S_KCOPY) begin
      we = 1'b1; waddr = {1'b0, ccnt};
      wdata = dig[159 - 8*ccnt -: 8];
    end
  end

  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = dig[159 - 32*ocnt -: 32];
  assign m_axis_tlast  = (ocnt == 3'd4);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; nxt <= N_BYTE;
      key_count <= '0; key_hashed <= 1'b0; msg_phase <= 1'b0; outer <= 1'b0;
      total <= '0; first_blk <= 1'b1; blk <= '0; ocnt <= '0; fin_len <= 1'b0;
      pidx <= '0; pad <= '0; ccnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!msg_phase) begin
              if (s_axis_tuser == hmac_pkg::CmdKey) begin
                if (key_count < 7'd64) begin
                  key_count <= key_count + 7'd1;
                  if (s_axis_tlast) begin
                    pidx <= '0; pad <= hmac_pkg::IpadByte; state <= S_KPREP;
                    total <= '0; first_blk <= 1'b1; blk <= '0;
                  end
                end else begin
                  // Key overflow: hash stored key then continue
                  if (!key_hashed) begin
                    key_hashed <= 1'b1;
                    total <= '0; first_blk <= 1'b1; blk <= '0;
                    pidx <= '0; pad <= 8'h00; state <= S_KPREP;
                    fin_len <= s_axis_tlast;
                    parked <= s_axis_tdata; // placed after the stored-key block is hashed
                  end else begin
                    blk[511 - 8*pos -: 8] <= s_axis_tdata;
                    total <= total + 64'd1;
                    if (pos == 6'd63) begin
                      nxt <= s_axis_tlast ? N_FIN : N_BYTE;
                      state <= S_WAIT;
                    end else if (s_axis_tlast) begin
                      state <= S_FIN; fin_len <= 1'b0;
                    end
                  end
                end
              end
            end else if (s_axis_tuser == hmac_pkg::CmdMsg) begin
              blk[511 - 8*pos -: 8] <= s_axis_tdata;
              total <= total + 64'd1;
              if (pos == 6'd63) begin
                nxt <= s_axis_tlast ? N_FIN : N_BYTE;
                state <= S_WAIT;
              end else if (s_axis_tlast) begin
                state <= S_FIN; fin_len <= 1'b0;
              end
            end
          end
        end
        // Issue key-memory read address
        S_KPREP: begin
          state <= S_PAD;
          pidx <= pidx + 7'd1;
        end
        // Place one padded key byte per cycle
        S_PAD: begin
          blk[511 - 8*pidx_m1[5:0] -: 8] <=
            ((pidx_m1 < key_count) ? key_rd : 8'h00) ^ pad;
          pidx <= pidx + 7'd1;
          if (pidx == 7'd64) begin
            total <= 64'd64;
            state <= S_WAIT;
            if (pad == 8'h00) nxt <= N_BYTE;
            else nxt <= (pad == hmac_pkg::IpadByte) ? N_IPAD : N_OPAD;
          end
        end
        S_WAIT: begin
          if (rsp.done) begin
            first_blk <= 1'b0;
            case (nxt)
              N_BYTE: begin
                if (key_hashed && !msg_phase && pad == 8'h00 && total == 64'd64
                    && key_count == 7'd64) begin
                  // first hashed-key block done: place parked byte
                  blk <= {parked, 504'd0};
                  total <= 64'd65; pad <= 8'hff;
                  state <= fin_len ? S_FIN : S_IDLE;
                  fin_len <= 1'b0;
                end else begin
                  blk <= '0; state <= S_IDLE;
                end
              end
              N_FIN: begin blk <= '0; state <= S_FIN; end
              N_IPAD: begin blk <= '0; msg_phase <= 1'b1; state <= S_IDLE; end
              N_OPAD: begin
                if (outer && total == 64'd64) begin
                  // Outer pad done: append inner digest then finish
                  blk <= {inner, 352'd0};
                  total <= 64'd84;
                  fin_len <= 1'b0;
                  state <= S_FIN;
                end else begin
                  blk <= '0; state <= S_IDIG;
                end
              end
              default: begin blk <= '0; state <= S_IDLE; end
            endcase
          end
        end
        // Padding: 0x80 marker, zeros, 64-bit bit count
        S_FIN: begin
          if (!fin_len) begin
            blk[511 - 8*pos -: 8] <= 8'h80;
            fin_len <= 1'b1;
            if (pos > 6'd55) begin
              nxt <= N_FIN; state <= S_WAIT;
            end
          end else begin
            blk[63:0] <= {total[60:0], 3'b000};
            state <= S_WAIT; nxt <= N_OPAD;
            fin_len <= 1'b0;
          end
        end
        // Digest ready after the length block
        S_IDIG: begin
          dig <= rsp.hash;
          if (!msg_phase) begin
            ccnt <= '0; state <= S_KCOPY;
          end else if (!outer) begin
            inner <= rsp.hash;
            outer <= 1'b1;
            pidx <= '0; pad <= hmac_pkg::OpadByte; state <= S_KPREP;
            total <= '0; first_blk <= 1'b1; blk <= '0;
          end else begin
            ocnt <= '0; state <= S_OUT;
          end
        end
        // Write hashed key digest into key memory
        S_KCOPY: begin
          ccnt <= ccnt + 5'd1;
          if (ccnt == 5'd19) begin
            key_count <= 7'd20;
            pidx <= '0; pad <= hmac_pkg::IpadByte; state <= S_KPREP;
            total <= '0; first_blk <= 1'b1; blk <= '0;
          end
        end
        S_KDIG: state <= S_IDLE;
        S_OUT: begin
          if (m_axis_tready) begin
            if (ocnt == 3'd4) begin
              ocnt <= '0;
              state <= S_IDLE; key_count <= '0; key_hashed <= 1'b0;
              msg_phase <= 1'b0; outer <= 1'b0; total <= '0; first_blk <= 1'b1;
              blk <= '0;
            end else begin
              ocnt <= ocnt + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
